// ===== hw/rtl/matrix_line_duplicate_checker_core_macros.svh =====
// Assertion macros used by the duplicate checker core.
`ifndef MATRIX_LINE_DUPLICATE_CHECKER_CORE_MACROS_SVH
`define MATRIX_LINE_DUPLICATE_CHECKER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define MLDC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define MLDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/mldc_pkg.sv =====
// Shared types and constants of the matrix line duplicate checker.
package mldc_pkg;

	localparam int S_TDATA_BITS   = 24;
	localparam int M_TDATA_BITS   = 16;
	localparam int REG_BITS       = 5;
	localparam int CFG_INDEX_BITS = 1;
	localparam int INDEX_BITS     = 4;
	localparam int IN_VALUE_BITS  = 8;
	localparam int OUT_VALUE_BITS = 8;
	localparam int STATUS_BITS    = 2;
	localparam int CELL_ADDR_BITS = 2 * INDEX_BITS;
	localparam int EPOCH_BITS     = 8;

	localparam logic [CFG_INDEX_BITS-1:0] REG_ROWS_IN_USE = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_COLS_IN_USE = 1'b1;

	typedef enum logic [1:0] {
		OP_WRITE     = 2'd0,
		OP_CHECK_ROW = 2'd1,
		OP_CHECK_COL = 2'd2
	} opcode_t;

	typedef enum logic [STATUS_BITS-1:0] {
		STATUS_WRITTEN   = 2'd0,
		STATUS_COORD_ERR = 2'd1,
		STATUS_NO_DUP    = 2'd2,
		STATUS_DUP       = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

// ===== hw/rtl/matrix_line_duplicate_checker_core.sv =====
// Top level of the matrix line duplicate checker: control, scan pipeline and stream ports.
// A write or a rejected operation goes straight to the result; a line check first scans its
// cells through the scan pipeline, reading one cell per cycle, and ends early on a repeat.
// A new transaction is taken only in the idle state, after the result has been registered.
// Reset clears registers and cells, then sweeps every entry of the seen memory;
// the same sweep follows every 255th line check, when the epoch tag wraps.
module matrix_line_duplicate_checker_core #(
	parameter int MAX_ROWS   = 16,
	parameter int MAX_COLS   = 16,
	parameter int VALUE_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port.
	input  logic                                cfg_we,
	input  logic [mldc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [mldc_pkg::REG_BITS-1:0]       cfg_wdata,
	// Input stream.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// s_tdata, from bit 0: opcode[1:0], row_index[5:2], col_index[9:6], cell_value[17:10].
	input  logic [mldc_pkg::S_TDATA_BITS-1:0]   s_tdata,
	// Result stream.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// m_tdata, from bit 0: status[1:0], repeated_value[9:2].
	output logic [mldc_pkg::M_TDATA_BITS-1:0]   m_tdata
);
	import mldc_pkg::*;

	`include "matrix_line_duplicate_checker_core_macros.svh"

	// Active line lengths never exceed what the 5-bit registers can hold.
	localparam int ROW_CAP = (MAX_ROWS < 31) ? MAX_ROWS : 31;
	localparam int COL_CAP = (MAX_COLS < 31) ? MAX_COLS : 31;
	localparam int PAD_BITS = M_TDATA_BITS - STATUS_BITS - OUT_VALUE_BITS;
	localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
	localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = {EPOCH_BITS{1'b1}};

	// Input fields.
	logic [1:0]               in_opcode;
	logic [INDEX_BITS-1:0]    in_row;
	logic [INDEX_BITS-1:0]    in_col;
	logic [IN_VALUE_BITS-1:0] in_value;

	assign in_opcode = s_tdata[1:0];
	assign in_row    = s_tdata[5:2];
	assign in_col    = s_tdata[9:6];
	assign in_value  = s_tdata[17:10];

	// Configuration registers and the clamped line lengths.
	logic [REG_BITS-1:0] rows_q;
	logic [REG_BITS-1:0] cols_q;
	logic [REG_BITS-1:0] n_rows;
	logic [REG_BITS-1:0] n_cols;

	assign n_rows = (rows_q > REG_BITS'(ROW_CAP)) ? REG_BITS'(ROW_CAP) : rows_q;
	assign n_cols = (cols_q > REG_BITS'(COL_CAP)) ? REG_BITS'(COL_CAP) : cols_q;

	state_t state_q;
	state_t state_d;

	// Operation held for the duration of a transaction.
	logic                    line_is_row_q;
	logic [INDEX_BITS-1:0]   line_idx_q;
	logic [REG_BITS-1:0]     count_q;
	logic [REG_BITS-1:0]     k_q;
	logic                    check_q;
	status_t                 status_q;
	logic [VALUE_BITS-1:0]   found_q;
	logic [EPOCH_BITS-1:0]   epoch_q;
	logic [VALUE_BITS-1:0]   clr_q;

	// Scan pipeline: stage 1 holds the cell read, stage 2 the seen-tag read.
	logic                    v_s1;
	logic                    hi_s1;
	logic                    v_s2;
	logic [VALUE_BITS-1:0]   val_s2;
	logic                    wr_v_q;
	logic [VALUE_BITS-1:0]   wr_val_q;

	// Result register.
	logic                    m_tvalid_q;
	status_t                 m_status_q;
	logic [OUT_VALUE_BITS-1:0] m_value_q;

	// Decode of the transaction offered at the input.
	logic                    accept;
	logic                    row_ok;
	logic                    col_ok;
	logic                    acc_scan;
	logic                    acc_cell_we;
	logic                    acc_line_row;
	logic [INDEX_BITS-1:0]   acc_line_idx;
	logic [REG_BITS-1:0]     acc_count;
	status_t                 acc_status;

	// Memory ports and scan control.
	logic                      cell_we;
	logic [CELL_ADDR_BITS-1:0] cell_raddr;
	logic [VALUE_BITS-1:0]     cell_rd;
	logic [VALUE_BITS-1:0]     s1_val;
	logic                      seen_we;
	logic [VALUE_BITS-1:0]     seen_waddr;
	logic [EPOCH_BITS-1:0]     seen_wdata;
	logic [EPOCH_BITS-1:0]     seen_rd;
	logic                      iss_ok;
	logic                      hit;
	logic                      scan_done;
	logic                      scan_stop;
	logic                      out_free;
	logic                      out_load;
	logic [INDEX_BITS-1:0]     k_low;

	assign accept = s_tvalid && s_tready;
	assign row_ok = {1'b0, in_row} < n_rows;
	assign col_ok = {1'b0, in_col} < n_cols;

	always_comb begin
		acc_scan     = 1'b0;
		acc_cell_we  = 1'b0;
		acc_line_row = 1'b1;
		acc_line_idx = in_row;
		acc_count    = '0;
		acc_status   = STATUS_COORD_ERR;
		case (in_opcode)
			OP_WRITE: begin
				if (row_ok && col_ok) begin
					acc_cell_we = 1'b1;
					acc_status  = STATUS_WRITTEN;
				end
			end
			OP_CHECK_ROW: begin
				if (row_ok) begin
					acc_scan  = 1'b1;
					acc_count = n_cols;
				end
			end
			OP_CHECK_COL: begin
				if (col_ok) begin
					acc_scan     = 1'b1;
					acc_count    = n_rows;
					acc_line_row = 1'b0;
					acc_line_idx = in_col;
				end
			end
			default: begin
			end
		endcase
	end

	// Cell address of the scan position; positions from sixteen upward lie beyond the
	// addressable cells and always read as zero.
	assign k_low      = k_q[INDEX_BITS-1:0];
	assign cell_raddr = line_is_row_q ? {line_idx_q, k_low} : {k_low, line_idx_q};
	assign s1_val     = hi_s1 ? '0 : cell_rd;

	// A value repeats when its tag carries the current epoch, or when the cell just before
	// it, whose tag write has not yet reached the memory read, held the same value.
	assign hit       = v_s2 && ((seen_rd == epoch_q) || (wr_v_q && (wr_val_q == val_s2)));
	assign scan_done = (k_q == count_q) && !v_s1 && !hit;
	assign scan_stop = (state_q == ST_SCAN) && (hit || scan_done);
	assign out_free  = !m_tvalid_q || m_tready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == {VALUE_BITS{1'b1}}) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = acc_scan ? ST_SCAN : ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (hit || scan_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = (check_q && (epoch_q == EPOCH_LAST)) ? ST_CLEAR : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// State outputs.
	always_comb begin
		s_tready   = 1'b0;
		cell_we    = 1'b0;
		iss_ok     = 1'b0;
		out_load   = 1'b0;
		seen_we    = 1'b0;
		seen_waddr = val_s2;
		seen_wdata = epoch_q;
		case (state_q)
			ST_CLEAR: begin
				seen_we    = 1'b1;
				seen_waddr = clr_q;
				seen_wdata = '0;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				cell_we  = s_tvalid && acc_cell_we;
			end
			ST_SCAN: begin
				iss_ok  = (k_q < count_q) && !hit;
				seen_we = v_s2 && !hit;
			end
			ST_FINISH: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	mldc_cell_mem #(
		.VALUE_BITS(VALUE_BITS)
	) u_cell_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cell_we),
		.waddr ({in_row, in_col}),
		.wdata (VALUE_BITS'(in_value)),
		.raddr (cell_raddr),
		.rdata (cell_rd)
	);

	mldc_seen_mem #(
		.VALUE_BITS(VALUE_BITS)
	) u_seen_mem (
		.clk  (clk),
		.we   (seen_we),
		.waddr(seen_waddr),
		.wdata(seen_wdata),
		.raddr(s1_val),
		.rdata(seen_rd)
	);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			rows_q     <= '0;
			cols_q     <= '0;
			epoch_q    <= EPOCH_FIRST;
			clr_q      <= '0;
			k_q        <= '0;
			check_q    <= 1'b0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			wr_v_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_ROWS_IN_USE: rows_q <= cfg_wdata;
					REG_COLS_IN_USE: cols_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept) begin
				k_q     <= '0;
				check_q <= acc_scan;
			end else if (iss_ok) begin
				k_q <= k_q + 1'b1;
			end
			if (scan_stop) begin
				v_s1   <= 1'b0;
				v_s2   <= 1'b0;
				wr_v_q <= 1'b0;
			end else begin
				v_s1   <= iss_ok;
				v_s2   <= v_s1;
				wr_v_q <= v_s2;
			end
			// Each finished check moves to a fresh epoch, so old tags no longer match.
			if (out_load && check_q) begin
				epoch_q <= (epoch_q == EPOCH_LAST) ? EPOCH_FIRST : epoch_q + 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			line_is_row_q <= acc_line_row;
			line_idx_q    <= acc_line_idx;
			count_q       <= acc_count;
			status_q      <= acc_status;
			found_q       <= '0;
		end else if (state_q == ST_SCAN) begin
			if (hit) begin
				status_q <= STATUS_DUP;
				found_q  <= val_s2;
			end else if (scan_done) begin
				status_q <= STATUS_NO_DUP;
			end
		end
		hi_s1    <= k_q[REG_BITS-1];
		val_s2   <= s1_val;
		wr_val_q <= val_s2;
		if (out_load) begin
			m_status_q <= status_q;
			m_value_q  <= OUT_VALUE_BITS'(found_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{PAD_BITS{1'b0}}, m_value_q, m_status_q};

	// The scan pipeline only carries cells while a check is running.
	`MLDC_ASSERT_IMP(a_pipe_in_scan, v_s1 || v_s2, state_q == ST_SCAN, "scan pipeline busy outside a check")
	// The scan position never runs past the line length.
	`MLDC_ASSERT_IMP(a_pos_bound, state_q == ST_SCAN, k_q <= count_q, "scan position beyond line length")
	// A repeated value is reported only together with a duplicate status.
	`MLDC_ASSERT_IMP(a_value_zero, m_tvalid_q && (m_status_q != STATUS_DUP), m_value_q == '0, "repeated value without duplicate")
	// Epoch zero is reserved for cleared tags and is never current once the sweep is over.
	`MLDC_ASSERT_NEXT(a_epoch_live, state_q != ST_CLEAR, epoch_q != '0, "epoch tag equals the cleared value")

endmodule

// ===== hw/rtl/mldc_cell_mem.sv =====
// Matrix cell store: synchronous memory with per-entry valid bits for reset to zero.
module mldc_cell_mem #(
	parameter int VALUE_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                we,
	input  logic [mldc_pkg::CELL_ADDR_BITS-1:0] waddr,
	input  logic [VALUE_BITS-1:0]               wdata,
	input  logic [mldc_pkg::CELL_ADDR_BITS-1:0] raddr,
	output logic [VALUE_BITS-1:0]               rdata
);
	import mldc_pkg::*;

	localparam int DEPTH = 1 << CELL_ADDR_BITS;

	logic [VALUE_BITS-1:0] mem [DEPTH];
	logic [DEPTH-1:0]      valid_q;
	logic [VALUE_BITS-1:0] rd_q;
	logic                  rd_valid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// A cell never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rd_valid_q <= valid_q[raddr];
		end
	end

	assign rdata = rd_valid_q ? rd_q : '0;

endmodule

// ===== hw/rtl/mldc_seen_mem.sv =====
// Seen-value memory: one epoch tag per possible cell value, synchronous read.
module mldc_seen_mem #(
	parameter int VALUE_BITS = 8
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [VALUE_BITS-1:0]           waddr,
	input  logic [mldc_pkg::EPOCH_BITS-1:0] wdata,
	input  logic [VALUE_BITS-1:0]           raddr,
	output logic [mldc_pkg::EPOCH_BITS-1:0] rdata
);
	import mldc_pkg::*;

	localparam int DEPTH = 1 << VALUE_BITS;

	logic [EPOCH_BITS-1:0] mem [DEPTH];

	// Read-before-write: a read of the entry being written returns the old tag.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
